@@ src/assert_macros.svh @@
// Assertion macros used by the dependency tree relation query engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define DTRQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dtrq assertion failed");

// Condition that must never be true outside reset.
`define DTRQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dtrq forbidden condition seen");

`else

`define DTRQ_ASSERT(lbl, clk, rst_n, prop)
`define DTRQ_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/dtrq_pkg.sv @@
// Types and constants of the dependency tree relation query block.
`timescale 1ns / 1ps

package dtrq_pkg;

    localparam int NODE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int ENTRY_W     = 10;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;

    localparam logic [2:0] REL_PARENT     = 3'd0;
    localparam logic [2:0] REL_CHILD      = 3'd1;
    localparam logic [2:0] REL_SIBLING    = 3'd2;
    localparam logic [2:0] REL_ANCESTOR   = 3'd3;
    localparam logic [2:0] REL_DESCENDANT = 3'd4;
    localparam logic [2:0] REL_OTHER      = 3'd5;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        logic [1:0] kind;
        node_t      parent;
    } entry_t;

    typedef struct packed {
        logic       is_root;
        logic [1:0] parent_kind;
        node_t      parent_index;
        node_t      second_node;
        node_t      first_node;
        logic [1:0] req_type;
    } request_t;

    typedef struct packed {
        logic       ancestor_valid;
        node_t      common_ancestor;
        logic [2:0] relation_code;
    } result_t;

    typedef struct packed {
        logic   we;
        node_t  waddr;
        entry_t wdata;
        node_t  raddr;
    } mem_req_t;

endpackage

@@ src/dependency_tree_relation_query_top.sv @@
// Top level of the dependency tree relation query block.
`timescale 1ns / 1ps

// A load or clear beat goes from idle straight to the finish state. A query
// beat reads both table entries, then runs, as needed, the ancestor walks, the
// depth walks, the equalizing steps and the joint climb; all chain steps share
// the one read port of the parent table RAM. A new beat is taken only once the
// previous item has handed its result to the output register, which holds it
// until it is taken.

module dependency_tree_relation_query_top #(
    parameter int MAX_NODES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_node[7:0], second_node[15:8], parent_index[23:16],
    // parent_kind[25:24], is_root[26], zero[31:27]
    input  logic [31:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // relation_code[2:0], common_ancestor[10:3], ancestor_valid[11], zero[15:12]
    output logic [15:0] m_axis_tdata
);

    dtrq_pkg::request_t req;
    dtrq_pkg::result_t  result;
    dtrq_pkg::mem_req_t mem_req;
    dtrq_pkg::entry_t   rdata;
    logic               ready;
    logic               start;
    logic               done;
    logic               out_free;
    logic               m_valid_reg, m_valid_next;
    dtrq_pkg::result_t  m_data_reg, m_data_next;

    assign req = '{is_root: s_axis_tdata[26], parent_kind: s_axis_tdata[25:24],
                   parent_index: s_axis_tdata[23:16], second_node: s_axis_tdata[15:8],
                   first_node: s_axis_tdata[7:0], req_type: s_axis_tuser};

    assign s_axis_tready = ready;
    assign start         = s_axis_tvalid && ready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    dtrq_ram #(
        .WIDTH (dtrq_pkg::ENTRY_W),
        .DEPTH (dtrq_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    dtrq_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .ready    (ready),
        .out_free (out_free),
        .done     (done),
        .result   (result),
        .mem_req  (mem_req),
        .rdata    (rdata)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done)
        begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_data_reg};

endmodule

@@ src/dtrq_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module dtrq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dtrq_engine.sv @@
// Sequencer that loads the parent table and walks parent chains for queries.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dtrq_engine #(
    parameter int MAX_NODES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dtrq_pkg::request_t req,
    output logic              ready,
    input  logic              out_free,
    output logic              done,
    output dtrq_pkg::result_t result,
    output dtrq_pkg::mem_req_t mem_req,
    input  dtrq_pkg::entry_t  rdata
);

    localparam int CW = $clog2(MAX_NODES + 2);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RDA     = 4'd1;
    localparam logic [3:0] S_CAPA    = 4'd2;
    localparam logic [3:0] S_REL     = 4'd3;
    localparam logic [3:0] S_ANC_CHK = 4'd4;
    localparam logic [3:0] S_ANC_RD  = 4'd5;
    localparam logic [3:0] S_LCA0    = 4'd6;
    localparam logic [3:0] S_DEP_CHK = 4'd7;
    localparam logic [3:0] S_DEP_RD  = 4'd8;
    localparam logic [3:0] S_EQ      = 4'd9;
    localparam logic [3:0] S_EQ_A    = 4'd10;
    localparam logic [3:0] S_EQ_B    = 4'd11;
    localparam logic [3:0] S_CL_CHK  = 4'd12;
    localparam logic [3:0] S_CL_A    = 4'd13;
    localparam logic [3:0] S_CL_B    = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    logic [3:0]      state_reg, state_next;
    logic            root_vld_reg, root_vld_next;
    dtrq_pkg::node_t root_idx_reg, root_idx_next;
    dtrq_pkg::node_t a_reg, a_next;
    dtrq_pkg::node_t b_reg, b_next;
    dtrq_pkg::entry_t ea_reg, ea_next;
    dtrq_pkg::entry_t eb_reg, eb_next;
    dtrq_pkg::node_t p_reg, p_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            dir_reg, dir_next;
    logic [CW-1:0]   ha_reg, ha_next;
    logic [CW-1:0]   hb_reg, hb_next;
    dtrq_pkg::node_t xa_reg, xa_next;
    dtrq_pkg::node_t xb_reg, xb_next;
    logic [2:0]      rel_reg, rel_next;
    dtrq_pkg::node_t lca_reg, lca_next;
    logic            lv_reg, lv_next;

    logic            p_is_root;
    dtrq_pkg::node_t anc_target;

    assign p_is_root  = root_vld_reg && (root_idx_reg == p_reg);
    assign anc_target = dir_reg ? b_reg : a_reg;

    assign ready  = (state_reg == S_IDLE);
    assign done   = (state_reg == S_FIN) && out_free;
    assign result = '{ancestor_valid: lv_reg, common_ancestor: lca_reg,
                      relation_code: rel_reg};

    always_comb
    begin
        state_next    = state_reg;
        root_vld_next = root_vld_reg;
        root_idx_next = root_idx_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        p_next        = p_reg;
        cnt_next      = cnt_reg;
        dir_next      = dir_reg;
        ha_next       = ha_reg;
        hb_next       = hb_reg;
        xa_next       = xa_reg;
        xb_next       = xb_reg;
        rel_next      = rel_reg;
        lca_next      = lca_reg;
        lv_next       = lv_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = req.first_node;
        mem_req.wdata = '{kind: req.parent_kind, parent: req.parent_index};
        mem_req.raddr = p_reg;

        case (state_reg)
            S_IDLE:
            begin
                mem_req.raddr = req.second_node;
                if (start)
                begin
                    a_next   = req.first_node;
                    b_next   = req.second_node;
                    rel_next = dtrq_pkg::REL_PARENT;
                    lca_next = '0;
                    lv_next  = 1'b0;
                    state_next = S_FIN;
                    case (req.req_type)
                        dtrq_pkg::REQ_LOAD:
                        begin
                            mem_req.we = 1'b1;
                            if (req.is_root)
                            begin
                                root_vld_next = 1'b1;
                                root_idx_next = req.first_node;
                            end
                        end
                        dtrq_pkg::REQ_QUERY:
                        begin
                            state_next = S_RDA;
                        end
                        dtrq_pkg::REQ_CLEAR:
                        begin
                            root_vld_next = 1'b0;
                            root_idx_next = '0;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RDA:
            begin
                eb_next       = rdata;
                mem_req.raddr = a_reg;
                state_next    = S_CAPA;
            end
            S_CAPA:
            begin
                ea_next    = rdata;
                state_next = S_REL;
            end
            S_REL:
            begin
                cnt_next = '0;
                if ((eb_reg.kind == dtrq_pkg::KIND_NORMAL) && (eb_reg.parent == a_reg))
                begin
                    rel_next   = dtrq_pkg::REL_PARENT;
                    state_next = S_LCA0;
                end
                else if ((ea_reg.kind == dtrq_pkg::KIND_NORMAL) && (ea_reg.parent == b_reg))
                begin
                    rel_next   = dtrq_pkg::REL_CHILD;
                    state_next = S_LCA0;
                end
                else if ((a_reg != b_reg) && (ea_reg.kind == dtrq_pkg::KIND_NORMAL)
                         && (eb_reg.kind == dtrq_pkg::KIND_NORMAL)
                         && (ea_reg.parent == eb_reg.parent))
                begin
                    rel_next   = dtrq_pkg::REL_SIBLING;
                    state_next = S_LCA0;
                end
                else if (eb_reg.kind == dtrq_pkg::KIND_NORMAL)
                begin
                    dir_next   = 1'b0;
                    p_next     = eb_reg.parent;
                    state_next = S_ANC_CHK;
                end
                else if (ea_reg.kind == dtrq_pkg::KIND_NORMAL)
                begin
                    dir_next   = 1'b1;
                    p_next     = ea_reg.parent;
                    state_next = S_ANC_CHK;
                end
                else
                begin
                    rel_next   = dtrq_pkg::REL_OTHER;
                    state_next = S_LCA0;
                end
            end
            S_ANC_CHK, S_ANC_RD:
            begin
                logic anc_fail;
                anc_fail = 1'b0;
                if (state_reg == S_ANC_CHK)
                begin
                    if (cnt_reg == CW'(MAX_NODES))
                    begin
                        anc_fail = 1'b1;
                    end
                    else if (p_reg == anc_target)
                    begin
                        rel_next   = dir_reg ? dtrq_pkg::REL_DESCENDANT
                                             : dtrq_pkg::REL_ANCESTOR;
                        state_next = S_LCA0;
                    end
                    else if (p_is_root)
                    begin
                        anc_fail = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ANC_RD;
                    end
                end
                else
                begin
                    if (rdata.kind != dtrq_pkg::KIND_NORMAL)
                    begin
                        anc_fail = 1'b1;
                    end
                    else
                    begin
                        p_next     = rdata.parent;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_ANC_CHK;
                    end
                end
                if (anc_fail)
                begin
                    if (!dir_reg && (ea_reg.kind == dtrq_pkg::KIND_NORMAL))
                    begin
                        dir_next   = 1'b1;
                        p_next     = ea_reg.parent;
                        cnt_next   = '0;
                        state_next = S_ANC_CHK;
                    end
                    else
                    begin
                        rel_next   = dtrq_pkg::REL_OTHER;
                        state_next = S_LCA0;
                    end
                end
            end
            S_LCA0:
            begin
                if ((ea_reg.kind == dtrq_pkg::KIND_PUNCT)
                    || (eb_reg.kind == dtrq_pkg::KIND_PUNCT))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = a_reg;
                    cnt_next   = '0;
                    dir_next   = 1'b0;
                    state_next = S_DEP_CHK;
                end
            end
            S_DEP_CHK:
            begin
                if (p_is_root)
                begin
                    if (!dir_reg)
                    begin
                        ha_next  = cnt_reg;
                        p_next   = b_reg;
                        cnt_next = '0;
                        dir_next = 1'b1;
                    end
                    else
                    begin
                        hb_next    = cnt_reg;
                        xa_next    = a_reg;
                        xb_next    = b_reg;
                        state_next = S_EQ;
                    end
                end
                else if (cnt_reg >= CW'(MAX_NODES))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DEP_RD;
                end
            end
            S_DEP_RD:
            begin
                if (rdata.kind != dtrq_pkg::KIND_NORMAL)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = rdata.parent;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_DEP_CHK;
                end
            end
            S_EQ:
            begin
                cnt_next = '0;
                if (ha_reg > hb_reg)
                begin
                    mem_req.raddr = xa_reg;
                    ha_next       = ha_reg - CW'(1);
                    state_next    = S_EQ_A;
                end
                else if (hb_reg > ha_reg)
                begin
                    mem_req.raddr = xb_reg;
                    hb_next       = hb_reg - CW'(1);
                    state_next    = S_EQ_B;
                end
                else
                begin
                    state_next = S_CL_CHK;
                end
            end
            S_EQ_A:
            begin
                xa_next    = rdata.parent;
                state_next = S_EQ;
            end
            S_EQ_B:
            begin
                xb_next    = rdata.parent;
                state_next = S_EQ;
            end
            S_CL_CHK:
            begin
                mem_req.raddr = xa_reg;
                if (xa_reg == xb_reg)
                begin
                    lca_next   = xa_reg;
                    lv_next    = 1'b1;
                    state_next = S_FIN;
                end
                else if (cnt_reg > CW'(MAX_NODES))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CL_A;
                end
            end
            S_CL_A:
            begin
                xa_next       = rdata.parent;
                mem_req.raddr = xb_reg;
                state_next    = S_CL_B;
            end
            S_CL_B:
            begin
                xb_next    = rdata.parent;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_CL_CHK;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            root_vld_reg <= 1'b0;
            root_idx_reg <= '0;
            cnt_reg      <= '0;
            dir_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            root_vld_reg <= root_vld_next;
            root_idx_reg <= root_idx_next;
            cnt_reg      <= cnt_next;
            dir_reg      <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        p_reg   <= p_next;
        ha_reg  <= ha_next;
        hb_reg  <= hb_next;
        xa_reg  <= xa_next;
        xb_reg  <= xb_next;
        rel_reg <= rel_next;
        lca_reg <= lca_next;
        lv_reg  <= lv_next;
    end

    `DTRQ_ASSERT(a_write_only_on_accept, clk, rst_n, mem_req.we |-> (start && (state_reg == S_IDLE)))
    `DTRQ_ASSERT(a_lca_from_climb, clk, rst_n, (state_reg == S_FIN && $rose(lv_reg)) |-> ($past(state_reg) == S_CL_CHK))
    `DTRQ_NEVER(n_walk_overrun, clk, rst_n, (cnt_reg > CW'(MAX_NODES + 1)))
    `DTRQ_ASSERT(a_done_returns_idle, clk, rst_n, done |=> (state_reg == S_IDLE))

endmodule

@@ bench/dependency_tree_relation_query_top_tb.sv @@
// Self-checking testbench for the dependency tree relation query block.
`timescale 1ns / 1ps

module dependency_tree_relation_query_top_tb;

    typedef dtrq_pkg::node_t    node_t;
    typedef dtrq_pkg::entry_t   entry_t;
    typedef dtrq_pkg::request_t request_t;
    typedef dtrq_pkg::result_t  result_t;

    localparam int TABLE_DEPTH = dtrq_pkg::TABLE_DEPTH;

    localparam logic [1:0] REQ_LOAD       = dtrq_pkg::REQ_LOAD;
    localparam logic [1:0] REQ_QUERY      = dtrq_pkg::REQ_QUERY;
    localparam logic [1:0] REQ_CLEAR      = dtrq_pkg::REQ_CLEAR;
    localparam logic [1:0] KIND_NORMAL    = dtrq_pkg::KIND_NORMAL;
    localparam logic [1:0] KIND_PUNCT     = dtrq_pkg::KIND_PUNCT;
    localparam logic [2:0] REL_PARENT     = dtrq_pkg::REL_PARENT;
    localparam logic [2:0] REL_CHILD      = dtrq_pkg::REL_CHILD;
    localparam logic [2:0] REL_SIBLING    = dtrq_pkg::REL_SIBLING;
    localparam logic [2:0] REL_ANCESTOR   = dtrq_pkg::REL_ANCESTOR;
    localparam logic [2:0] REL_DESCENDANT = dtrq_pkg::REL_DESCENDANT;
    localparam logic [2:0] REL_OTHER      = dtrq_pkg::REL_OTHER;

    localparam int WALK_LIMIT    = 256;
    localparam int ITEM_GOAL     = 540;
    localparam int DIRECTED_ROWS = 26;
    localparam int SETTLE_CYCLES = 13 * WALK_LIMIT + 200;
    localparam int DRAIN_CYCLES  = 50000;
    localparam int LONG_HOLD     = 300;

    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam logic [1:0] KIND_NONE  = 2'd1;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [2:0] REL_NONE   = 3'd0;

    typedef struct packed {
        logic [1:0] req;
        node_t      a;
        node_t      b;
        node_t      pidx;
        logic [1:0] kind;
        logic       root;
        logic       typed;
        logic [2:0] rel;
        node_t      lca;
        logic       valid;
    } script_row_t;

    // Loads and clears answer all zeros; rows with typed clear are checked by the predictor.
    localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
        '{REQ_LOAD,  8'd255, 8'd0,   8'd255, KIND_NONE,   1'b1, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd0,   8'd0,   8'd255, KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd1,   8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd2,   8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd3,   8'd0,   8'd1,   KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd128, 8'd0,   8'hAA,  KIND_PUNCT,  1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd64,  8'd0,   8'h55,  KIND_SPARE,  1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd0,   8'd1,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd1,   8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd1,   8'd2,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd255, 8'd3,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd3,   8'd255, 8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd255, 8'd255, 8'd255, KIND_SPARE,  1'b1, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd128, 8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b1, REL_OTHER, 8'd0, 1'b0},
        '{REQ_QUERY, 8'd64,  8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_SPARE, 8'd1,   8'd2,   8'd0,   KIND_NORMAL, 1'b1, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd1,   8'd255, 8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd4,   8'd0,   8'd3,   KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd4,   8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_CLEAR, 8'd0,   8'd0,   8'd0,   KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd4,   8'd1,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd10,  8'd0,   8'd11,  KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd11,  8'd0,   8'd10,  KIND_NORMAL, 1'b0, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_LOAD,  8'd255, 8'd0,   8'd255, KIND_NONE,   1'b1, 1'b1, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd10,  8'd3,   8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0},
        '{REQ_QUERY, 8'd11,  8'd10,  8'd0,   KIND_NORMAL, 1'b0, 1'b0, REL_NONE,  8'd0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    entry_t  tree_table [TABLE_DEPTH];
    bit      entry_written [TABLE_DEPTH];
    bit      root_set;
    node_t   root_at;
    result_t pending_answers [$];

    int mismatch_count;
    int random_beats;
    int phase_sel;
    int send_idle_pct;
    int take_idle_pct;
    int hold_left;
    bit held_once;
    bit deep_done;

    dependency_tree_relation_query_top #(
        .MAX_NODES(WALK_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("dependency_tree_relation_query_top_tb failed");
        $finish;
    end

    task automatic flag_error(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic bit has_link(node_t n);
        return tree_table[n].kind == KIND_NORMAL;
    endfunction

    function automatic bit is_root_at(node_t n);
        return root_set && root_at == n;
    endfunction

    // True if anc sits on the parent chain of low, the root included.
    function automatic bit lies_above(node_t anc, node_t low);
        node_t p;
        if (!has_link(low))
            return 1'b0;
        p = tree_table[low].parent;
        for (int i = 0; i < WALK_LIMIT; i++)
        begin
            if (p == anc)
                return 1'b1;
            if (is_root_at(p) || !has_link(p))
                return 1'b0;
            p = tree_table[p].parent;
        end
        return 1'b0;
    endfunction

    function automatic bit depth_to_root(node_t n, output int depth);
        node_t p;
        p = n;
        depth = 0;
        while (!is_root_at(p))
        begin
            if (depth >= WALK_LIMIT || !has_link(p))
                return 1'b0;
            p = tree_table[p].parent;
            depth++;
        end
        return 1'b1;
    endfunction

    function automatic bit meeting_point(node_t a, node_t b, output node_t lca);
        int    ha;
        int    hb;
        node_t pa;
        node_t pb;
        lca = '0;
        if (tree_table[a].kind == KIND_PUNCT || tree_table[b].kind == KIND_PUNCT)
            return 1'b0;
        if (!depth_to_root(a, ha) || !depth_to_root(b, hb))
            return 1'b0;
        pa = a;
        pb = b;
        for (; ha > hb; ha--)
            pa = tree_table[pa].parent;
        for (; hb > ha; hb--)
            pb = tree_table[pb].parent;
        for (int i = 0; i <= WALK_LIMIT && pa != pb; i++)
        begin
            pa = tree_table[pa].parent;
            pb = tree_table[pb].parent;
        end
        if (pa != pb)
            return 1'b0;
        lca = pa;
        return 1'b1;
    endfunction

    function automatic logic [2:0] relation_between(node_t a, node_t b);
        if (has_link(b) && tree_table[b].parent == a)
            return REL_PARENT;
        if (has_link(a) && tree_table[a].parent == b)
            return REL_CHILD;
        if (a != b && has_link(a) && has_link(b) && tree_table[a].parent == tree_table[b].parent)
            return REL_SIBLING;
        if (lies_above(a, b))
            return REL_ANCESTOR;
        if (lies_above(b, a))
            return REL_DESCENDANT;
        return REL_OTHER;
    endfunction

    function automatic result_t apply_request(request_t rq);
        result_t ans;
        node_t   lca;
        ans = '0;
        case (rq.req_type)
            REQ_LOAD:
            begin
                tree_table[rq.first_node].kind   = rq.parent_kind;
                tree_table[rq.first_node].parent = rq.parent_index;
                entry_written[rq.first_node] = 1'b1;
                if (rq.is_root)
                begin
                    root_set = 1'b1;
                    root_at  = rq.first_node;
                end
            end
            REQ_QUERY:
            begin
                ans.relation_code = relation_between(rq.first_node, rq.second_node);
                if (meeting_point(rq.first_node, rq.second_node, lca))
                begin
                    ans.common_ancestor = lca;
                    ans.ancestor_valid  = 1'b1;
                end
            end
            REQ_CLEAR:
                root_set = 1'b0;
            default:
                ;
        endcase
        return ans;
    endfunction

    // A query is only issued when every entry along both parent chains has been written.
    function automatic bit chain_written(node_t n);
        node_t p;
        p = n;
        for (int i = 0; i <= WALK_LIMIT + 1; i++)
        begin
            if (!entry_written[p])
                return 1'b0;
            if (tree_table[p].kind != KIND_NORMAL)
                return 1'b1;
            p = tree_table[p].parent;
        end
        return 1'b1;
    endfunction

    function automatic request_t beat_of(logic [1:0] req, node_t a, node_t b, node_t pidx,
                                         logic [1:0] kind, logic root);
        request_t rq;
        rq.req_type     = req;
        rq.first_node   = a;
        rq.second_node  = b;
        rq.parent_index = pidx;
        rq.parent_kind  = kind;
        rq.is_root      = root;
        return rq;
    endfunction

    task automatic send_beat(request_t rq, bit typed, result_t fixed);
        result_t ans;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, rq.is_root, rq.parent_kind, rq.parent_index,
                          rq.second_node, rq.first_node};
        s_axis_tuser  <= rq.req_type;
        do @(posedge clk); while (!s_axis_tready);
        ans = apply_request(rq);
        pending_answers.insert(pending_answers.size(), typed ? fixed : ans);
    endtask

    task automatic send_random(request_t rq);
        if (rq.req_type != REQ_SPARE)
            random_beats++;
        phase_sel = (random_beats * 3) / ITEM_GOAL;
        if (phase_sel > 2)
            phase_sel = 2;
        send_idle_pct = (phase_sel == 0) ? 37 : (phase_sel == 1) ? 59 : 0;
        take_idle_pct = (phase_sel == 0) ? 59 : (phase_sel == 1) ? 37 : 0;
        send_beat(rq, 1'b0, '0);
    endtask

    function automatic logic [1:0] random_kind();
        int r;
        r = $urandom_range(99);
        return (r < 85) ? KIND_NORMAL : (r < 92) ? KIND_PUNCT : (r < 96) ? KIND_NONE : KIND_SPARE;
    endfunction

    // Builds one tree on random node numbers, then asks questions about it with some noise mixed in.
    task automatic grow_tree();
        node_t      pool [TABLE_DEPTH];
        node_t      tmp;
        node_t      par;
        node_t      a;
        node_t      b;
        logic [1:0] kind;
        bit         chain_mode;
        bit         ok;
        int         n;
        int         j;
        int         r;
        int         queries;
        chain_mode = !deep_done && random_beats >= 200;
        deep_done  = deep_done || chain_mode;
        n = chain_mode ? 100 : $urandom_range(2, 24);
        for (int i = 0; i < TABLE_DEPTH; i++)
            pool[i] = node_t'(i);
        for (int i = 0; i < n; i++)
        begin
            j = $urandom_range(i, TABLE_DEPTH - 1);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        if ($urandom_range(3) != 0)
            send_random(beat_of(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                                2'($urandom), 1'($urandom)));
        r = $urandom_range(9);
        kind = (r < 6) ? KIND_NONE : (r < 8) ? KIND_NORMAL : (r < 9) ? KIND_PUNCT : KIND_SPARE;
        send_random(beat_of(REQ_LOAD, pool[0], 8'($urandom), 8'($urandom), kind, 1'b1));
        for (int i = 1; i < n; i++)
        begin
            par = chain_mode ? pool[i-1] : pool[$urandom_range(0, i - 1)];
            if ($urandom_range(99) < 3)
                par = 8'($urandom);
            send_random(beat_of(REQ_LOAD, pool[i], 8'($urandom), par, random_kind(),
                                $urandom_range(99) < 2));
        end
        queries = chain_mode ? 20 : $urandom_range(4, 16);
        for (int q = 0; q < queries; q++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_random(beat_of(REQ_SPARE, 8'($urandom), 8'($urandom), 8'($urandom),
                                    2'($urandom), 1'($urandom)));
            else if (r < 7)
                send_random(beat_of(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                                    2'($urandom), 1'($urandom)));
            else if (r < 11)
                send_random(beat_of(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                                    2'($urandom), $urandom_range(9) == 0));
            else
            begin
                ok = 1'b0;
                for (int t = 0; t < 4 && !ok; t++)
                begin
                    a = ($urandom_range(9) == 0) ? 8'($urandom) : pool[$urandom_range(0, n - 1)];
                    b = ($urandom_range(9) == 0) ? 8'($urandom) : pool[$urandom_range(0, n - 1)];
                    ok = chain_written(a) && chain_written(b);
                end
                if (ok)
                    send_random(beat_of(REQ_QUERY, a, b, 8'($urandom), 2'($urandom),
                                        1'($urandom)));
                else
                    send_random(beat_of(REQ_SPARE, a, b, 8'($urandom), 2'($urandom),
                                        1'($urandom)));
            end
        end
    endtask

    // The receiver holds off once for a long stretch when the last phase begins.
    always @(posedge clk)
    begin
        if (phase_sel == 2 && !held_once)
        begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin : answer_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[11:0]);
            if (pending_answers.size() == 0)
                flag_error($sformatf("result beat 0x%03h with no result expected",
                                     m_axis_tdata[11:0]));
            else
            begin
                want = pending_answers[0];
                pending_answers.delete(0);
                if (got.relation_code !== want.relation_code)
                    flag_error($sformatf("relation_code %0d, expected %0d",
                                         got.relation_code, want.relation_code));
                if (got.common_ancestor !== want.common_ancestor)
                    flag_error($sformatf("common_ancestor %0d, expected %0d",
                                         got.common_ancestor, want.common_ancestor));
                if (got.ancestor_valid !== want.ancestor_valid)
                    flag_error($sformatf("ancestor_valid %0b, expected %0b",
                                         got.ancestor_valid, want.ancestor_valid));
            end
        end
    end

    initial
    begin
        result_t fixed;
        int      waited;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        m_axis_tready = 1'b0;
        mismatch_count = 0;
        random_beats  = 0;
        phase_sel     = 0;
        send_idle_pct = 37;
        take_idle_pct = 59;
        hold_left     = 0;
        held_once     = 1'b0;
        deep_done     = 1'b0;
        root_set      = 1'b0;
        root_at       = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tree_table[i]    = '0;
            entry_written[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            fixed.relation_code   = SCRIPT[k].rel;
            fixed.common_ancestor = SCRIPT[k].lca;
            fixed.ancestor_valid  = SCRIPT[k].valid;
            send_beat(beat_of(SCRIPT[k].req, SCRIPT[k].a, SCRIPT[k].b, SCRIPT[k].pidx,
                              SCRIPT[k].kind, SCRIPT[k].root), SCRIPT[k].typed, fixed);
        end

        while (random_beats < ITEM_GOAL)
            grow_tree();
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending_answers.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_answers.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_answers.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("dependency_tree_relation_query_top_tb passed");
        else
            $display("dependency_tree_relation_query_top_tb failed");
        $finish;
    end

endmodule
